@@ sv/wid_pkg.sv @@
package wid_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned CNT_W  = 6;

	// final iteration of the radix-2 loop
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WORD_W - 1);

	typedef struct packed {
		logic load;  // capture operands, set up special cases
		logic step;  // one shift/subtract iteration
		logic fix;   // sign fix-up, write output register
	} wid_cmd_t;

	typedef struct packed {
		logic special;  // result already known at load, skip iterations
	} wid_sts_t;

endpackage

@@ sv/wid_datapath.sv @@
module wid_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  wid_pkg::wid_cmd_t         cmd,
	output wid_pkg::wid_sts_t         sts,
	input  logic                      op,
	input  logic [wid_pkg::WORD_W-1:0] hi,
	input  logic [wid_pkg::WORD_W-1:0] lo,
	input  logic [wid_pkg::WORD_W-1:0] dv,
	output logic [wid_pkg::WORD_W-1:0] quo,
	output logic [wid_pkg::WORD_W-1:0] rem
);
	import wid_pkg::*;

	// quo_q shifts dividend bits out at the top and quotient bits in at the bottom
	logic [WORD_W-1:0] rem_q, quo_q, div_q, out_quo_q, out_rem_q;
	logic              xneg_q, yneg_q, special_q;

	logic              xneg, yneg, sgn_zero, uns_ovf;
	logic [WORD_W-1:0] ax, ay;
	logic [WORD_W-1:0] shifted;
	logic [WORD_W:0]   diff;
	logic              ge, r_nz;
	logic [WORD_W-1:0] q_fix, r_fix;

	assign xneg     = lo[WORD_W-1];
	assign yneg     = dv[WORD_W-1];
	assign ax       = xneg ? (~lo + 1'b1) : lo;
	assign ay       = yneg ? (~dv + 1'b1) : dv;
	assign sgn_zero = (dv == '0);
	assign uns_ovf  = (hi >= dv);

	assign shifted = {rem_q[WORD_W-2:0], quo_q[WORD_W-1]};
	assign diff    = {rem_q[WORD_W-1], shifted} - {1'b0, div_q};
	assign ge      = rem_q[WORD_W-1] | ~diff[WORD_W];

	// floored correction of the magnitude result
	assign r_nz = (rem_q != '0);

	always_comb begin
		if (xneg_q ^ yneg_q) begin
			q_fix = r_nz ? ~quo_q : (~quo_q + 1'b1);
		end else begin
			q_fix = quo_q;
		end
		case ({xneg_q, yneg_q})
			2'b11:   r_fix = ~rem_q + 1'b1;
			2'b01:   r_fix = r_nz ? (rem_q - div_q) : rem_q;
			2'b10:   r_fix = r_nz ? (div_q - rem_q) : rem_q;
			default: r_fix = rem_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xneg_q    <= 1'b0;
			yneg_q    <= 1'b0;
			special_q <= 1'b0;
		end else if (cmd.load) begin
			if (op) begin
				special_q <= sgn_zero;
				xneg_q    <= xneg & ~sgn_zero;
				yneg_q    <= yneg & ~sgn_zero;
			end else begin
				special_q <= uns_ovf;
				xneg_q    <= 1'b0;
				yneg_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (op) begin
				quo_q <= sgn_zero ? '0 : ax;
				rem_q <= sgn_zero ? lo : '0;
				div_q <= ay;
			end else begin
				quo_q <= uns_ovf ? hi : lo;
				rem_q <= uns_ovf ? lo : hi;
				div_q <= dv;
			end
		end else if (cmd.step) begin
			rem_q <= ge ? diff[WORD_W-1:0] : shifted;
			quo_q <= {quo_q[WORD_W-2:0], ge};
		end
		if (cmd.fix) begin
			out_quo_q <= q_fix;
			out_rem_q <= r_fix;
		end
	end

	assign sts.special = special_q;
	assign quo         = out_quo_q;
	assign rem         = out_rem_q;

endmodule

@@ sv/wid_ctrl.sv @@
module wid_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_valid,
	output logic              s_ready,
	output logic              m_valid,
	input  logic              m_ready,
	output wid_pkg::wid_cmd_t cmd,
	input  wid_pkg::wid_sts_t sts
);
	import wid_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIX
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = ~out_valid_q | m_ready;
	assign s_ready  = (state_q == ST_IDLE);
	assign m_valid  = out_valid_q;

	assign cmd.load = (state_q == ST_IDLE) & s_valid;
	assign cmd.step = (state_q == ST_RUN) & ~sts.special;
	assign cmd.fix  = (state_q == ST_FIX) & out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.fix) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_valid) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					if (sts.special) begin
						state_q <= ST_FIX;
					end else begin
						if (cnt_q == LAST_STEP) begin
							state_q <= ST_FIX;
						end
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FIX: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_valid && s_ready |=> state_q == ST_RUN && cnt_q == '0)
		else $error("accepted transfer did not start iterations");

	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN && !sts.special && cnt_q == LAST_STEP |=> state_q == ST_FIX)
		else $error("loop did not end after final step");

	a_fix_fills: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fix |=> out_valid_q && state_q == ST_IDLE)
		else $error("fix-up did not present a result");

endmodule

@@ sv/wide_integer_divider_unit.sv @@
// channel   | direction | handshake                     | payload
// s_axis    | in        | s_axis_tvalid / s_axis_tready | tuser: operation; tdata: operands
// m_axis    | out       | m_axis_tvalid / m_axis_tready | tdata: quotient, remainder
//
// One transfer in flight at a time; from accept to result a regular divide
// runs 1 load, 64 radix-2 shift/subtract steps and 1 sign fix-up.
// Overflowing unsigned divides and signed divides by zero skip the 64 steps.
// Iterations run on a single 65-bit subtractor, one quotient bit per cycle.
// Reset is asynchronous, active low; it clears the controller and the datapath
// sign/special flags, operand and output words are left as they are.
// A stalled m_axis result sits in an output register; the next operand
// transfer is taken meanwhile, and only its final fix-up cycle waits.
module wide_integer_divider_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [191:0] s_axis_tdata,  // dividend_high, dividend_low, divisor
	input  logic         s_axis_tuser,  // operation (0 unsigned 128/64, 1 signed floored)
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata   // quotient, remainder
);
	import wid_pkg::*;

	wid_cmd_t          cmd;
	wid_sts_t          sts;
	logic [WORD_W-1:0] quo, rem;

	// controller: sequencing, iteration count, output handshake
	wid_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.cmd     (cmd),
		.sts     (sts)
	);

	// datapath: operand magnitudes, restoring divide loop, floored fix-up
	wid_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.op     (s_axis_tuser),
		.hi     (s_axis_tdata[WORD_W-1:0]),
		.lo     (s_axis_tdata[2*WORD_W-1:WORD_W]),
		.dv     (s_axis_tdata[3*WORD_W-1:2*WORD_W]),
		.quo    (quo),
		.rem    (rem)
	);

	assign m_axis_tdata = {rem, quo};

endmodule

@@ dv/tb_wide_integer_divider_unit.sv @@
module tb_wide_integer_divider_unit;

	import wid_pkg::*;

	// tuser encoding on the operand stream
	typedef enum logic {
		OP_UNSIGNED = 1'b0,  // 128/64 unsigned divide
		OP_SIGNED   = 1'b1   // 64-bit floored signed divide
	} div_op_t;

	typedef struct packed {
		logic [WORD_W-1:0] quotient;
		logic [WORD_W-1:0] remainder;
	} div_result_t;

	localparam int unsigned DIV_LATENCY = 66;      // accept to result, regular divide
	localparam int unsigned HOLD_CYCLES = 400;     // long output back-pressure window
	localparam int unsigned CYCLE_LIMIT = 600000;  // watchdog

	localparam logic [WORD_W-1:0] ALL_ONES = '1;
	localparam logic [WORD_W-1:0] ONE_W    = {{(WORD_W-1){1'b0}}, 1'b1};
	localparam logic [WORD_W-1:0] MIN_S64  = {1'b1, {(WORD_W-1){1'b0}}};
	localparam logic [WORD_W-1:0] MAX_S64  = {1'b0, {(WORD_W-1){1'b1}}};

	logic         clk           = 1'b0;
	logic         arst_n        = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [191:0] s_axis_tdata  = '0;   // dividend_high, dividend_low, divisor
	logic         s_axis_tuser  = 1'b0; // operation
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;         // quotient, remainder

	// expected quotient/remainder pairs, oldest first
	div_result_t expected_results[$];
	div_result_t oldest_expected;

	int unsigned error_count   = 0;
	int unsigned cycle_count   = 0;
	int unsigned divides_sent  = 0;
	int unsigned unsigned_sent = 0;
	int unsigned signed_sent   = 0;
	int unsigned special_sent  = 0;

	// no_idle: both sides stream without gaps
	// hold_request: receiver picks it up and stalls that many cycles
	bit          no_idle      = 1'b0;
	int unsigned hold_request = 0;
	int unsigned hold_left    = 0;

	wide_integer_divider_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Expected result of one divide.
	// Unsigned: a high word at or above the divisor (zero divisor too) means
	// the quotient cannot fit; the words come back unchanged.
	// Signed: work on magnitudes, then floor and give the remainder the
	// divisor's sign. Zero divisor returns quotient 0, remainder = dividend.
	function automatic div_result_t predict_divide(div_op_t op, logic [WORD_W-1:0] hi,
			logic [WORD_W-1:0] lo, logic [WORD_W-1:0] dv);
		div_result_t res;
		logic [2*WORD_W-1:0] num;
		logic [2*WORD_W-1:0] q_wide;
		logic [2*WORD_W-1:0] r_wide;
		logic [WORD_W-1:0] mag_x;
		logic [WORD_W-1:0] mag_y;
		logic [WORD_W-1:0] q;
		logic [WORD_W-1:0] r;
		logic x_neg;
		logic y_neg;
		if (op == OP_UNSIGNED) begin
			if (hi >= dv) begin
				res.quotient  = hi;
				res.remainder = lo;
			end else begin
				num           = {hi, lo};
				q_wide        = num / {{WORD_W{1'b0}}, dv};
				r_wide        = num % {{WORD_W{1'b0}}, dv};
				res.quotient  = q_wide[WORD_W-1:0];
				res.remainder = r_wide[WORD_W-1:0];
			end
		end else if (dv == '0) begin
			res.quotient  = '0;
			res.remainder = lo;
		end else begin
			x_neg = lo[WORD_W-1];
			y_neg = dv[WORD_W-1];
			mag_x = x_neg ? -lo : lo;
			mag_y = y_neg ? -dv : dv;
			q     = mag_x / mag_y;
			r     = mag_x % mag_y;
			if (x_neg != y_neg) begin
				// true quotient negative: round toward minus infinity
				if (r != '0) begin
					q = ~q;
					r = mag_y - r;
				end else begin
					q = -q;
				end
			end
			if (y_neg)
				r = -r;
			res.quotient  = q;
			res.remainder = r;
		end
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0d] ERROR: %s", cycle_count, msg);
		error_count++;
	endtask

	// One operand transfer, with a random idle gap ahead of it.
	task automatic send_divide(input div_op_t op, input logic [WORD_W-1:0] hi,
			input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] dv);
		int unsigned gap;
		gap = 0;
		if (!no_idle) begin
			while ($urandom_range(99) < 23)
				gap++;
			// now and then a long gap, so the block drains completely
			if ($urandom_range(99) < 2)
				gap += $urandom_range(120);
		end
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {dv, lo, hi};
		do @(posedge clk); while (!s_axis_tready);
		expected_results.push_back(predict_divide(op, hi, lo, dv));
		divides_sent++;
		if (op == OP_UNSIGNED) begin
			unsigned_sent++;
			if (hi >= dv)
				special_sent++;
		end else begin
			signed_sent++;
			if (dv == '0 || (lo == MIN_S64 && dv == ALL_ONES))
				special_sent++;
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	function automatic logic [WORD_W-1:0] rand_word();
		logic [WORD_W-1:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(7))
			0: w = w >> $urandom_range(WORD_W - 1);     // small positive
			1: w = ~(w >> $urandom_range(WORD_W - 1));  // small negative
			2: begin
				case ($urandom_range(5))
					0: w = '0;
					1: w = ONE_W;
					2: w = ALL_ONES;
					3: w = MIN_S64;
					4: w = MAX_S64;
					default: w = MIN_S64 + ONE_W;
				endcase
			end
			default: ;
		endcase
		return w;
	endfunction

	// Mostly real divides (unsigned with high word below divisor), with a
	// share of overflows, zero divisors and most-negative / -1.
	task automatic random_operands(output div_op_t op, output logic [WORD_W-1:0] hi,
			output logic [WORD_W-1:0] lo, output logic [WORD_W-1:0] dv);
		op = $urandom_range(1) ? OP_SIGNED : OP_UNSIGNED;
		hi = rand_word();
		lo = rand_word();
		dv = rand_word();
		if (op == OP_UNSIGNED) begin
			if ($urandom_range(99) < 80) begin
				if (dv == '0)
					dv = {$urandom, $urandom} | ONE_W;
				hi = hi % dv;
			end
		end else begin
			case ($urandom_range(39))
				0: dv = '0;
				1: begin
					lo = MIN_S64;
					dv = ALL_ONES;
				end
				default: if (dv == '0) dv = ONE_W;
			endcase
		end
	endtask

	task automatic test_directed_unsigned();
		send_divide(OP_UNSIGNED, '0, '0, ONE_W);
		send_divide(OP_UNSIGNED, '0, ALL_ONES, ONE_W);
		send_divide(OP_UNSIGNED, ALL_ONES - ONE_W, ALL_ONES, ALL_ONES);  // largest quotient
		send_divide(OP_UNSIGNED, '0, 64'd5, ALL_ONES);
		send_divide(OP_UNSIGNED, MAX_S64, ALL_ONES, MIN_S64);        // top-bit carry path
		send_divide(OP_UNSIGNED, 64'h1234, 64'hdead_beef_0000_0001, 64'h1234);  // high == divisor
		send_divide(OP_UNSIGNED, ALL_ONES, ALL_ONES, ALL_ONES);      // overflow
		send_divide(OP_UNSIGNED, 64'h5555, 64'haaaa, '0);            // zero divisor
		send_divide(OP_UNSIGNED, '0, '0, '0);
		send_divide(OP_UNSIGNED, ONE_W, '0, 64'd2);
		wait_drained();
	endtask

	task automatic test_directed_signed();
		send_divide(OP_SIGNED, ALL_ONES, 64'd42, '0);     // zero divisor
		send_divide(OP_SIGNED, '0, MIN_S64, ALL_ONES);    // wraps, no flag
		send_divide(OP_SIGNED, '0, MIN_S64, ONE_W);
		send_divide(OP_SIGNED, '0, -64'd7, 64'd2);
		send_divide(OP_SIGNED, '0, 64'd7, -64'd2);
		send_divide(OP_SIGNED, '0, -64'd7, -64'd2);
		send_divide(OP_SIGNED, '0, 64'd7, 64'd2);
		send_divide(OP_SIGNED, '0, -64'd6, 64'd3);        // exact, negative dividend
		send_divide(OP_SIGNED, '0, 64'd6, -64'd3);        // exact, negative divisor
		send_divide(OP_SIGNED, '0, MAX_S64, MIN_S64);
		send_divide(OP_SIGNED, '0, MIN_S64, MIN_S64);
		send_divide(OP_SIGNED, ALL_ONES, ALL_ONES, MAX_S64);  // high word must be ignored
		send_divide(OP_SIGNED, '0, '0, ALL_ONES);
		wait_drained();
	endtask

	task automatic test_random_mix(input int unsigned count);
		div_op_t op;
		logic [WORD_W-1:0] hi;
		logic [WORD_W-1:0] lo;
		logic [WORD_W-1:0] dv;
		repeat (count) begin
			random_operands(op, hi, lo, dv);
			send_divide(op, hi, lo, dv);
		end
		wait_drained();
	endtask

	// both sides stream flat out for a while
	task automatic test_back_to_back(input int unsigned count);
		no_idle = 1'b1;
		test_random_mix(count);
		no_idle = 1'b0;
	endtask

	// receiver stalls for a long window while operands keep coming; the
	// output register fills, then the next divide parks in fix-up and the
	// input stream backs up
	task automatic test_output_stall();
		hold_request = HOLD_CYCLES;
		test_random_mix(8);
	endtask

	// receiver: random back-pressure, or a counted hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (hold_request != 0) begin
			hold_left     = hold_request - 1;
			hold_request  = 0;
			m_axis_tready <= 1'b0;
		end else if (no_idle) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= 23);
		end
	end

	// result checker: every m_axis transfer against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result q=%h r=%h",
					m_axis_tdata[63:0], m_axis_tdata[127:64]));
			end else begin
				oldest_expected = expected_results.pop_front();
				if (m_axis_tdata[63:0] !== oldest_expected.quotient)
					report_mismatch($sformatf("quotient %h, expected %h",
						m_axis_tdata[63:0], oldest_expected.quotient));
				if (m_axis_tdata[127:64] !== oldest_expected.remainder)
					report_mismatch($sformatf("remainder %h, expected %h",
						m_axis_tdata[127:64], oldest_expected.remainder));
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("watchdog expired with %0d results outstanding", expected_results.size());
		$display("FAIL wide_integer_divider_unit");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_unsigned();
		test_directed_signed();
		test_random_mix(600);
		test_back_to_back(120);
		test_output_stall();

		// anything arriving after the drain is flagged by the checker
		repeat (2 * DIV_LATENCY) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

		$display("Ran %0d divides (%0d unsigned, %0d signed, %0d overflow/zero/wrap cases)",
			divides_sent, unsigned_sent, signed_sent, special_sent);
		$display("with random gaps on both sides, a gap-free stretch and a %0d-cycle output stall",
			HOLD_CYCLES);
		if (error_count == 0)
			$display("PASS wide_integer_divider_unit");
		else
			$display("FAIL wide_integer_divider_unit");
		$finish;
	end

endmodule
